>>> rtl/vti_pkg.sv
`default_nettype none

package vti_pkg;

	// Fixed field widths of the command word and the result word.
	localparam int COORD_W = 13;
	localparam int ADDR_W = 15;
	localparam int VAL_W = 16;
	localparam int LIMIT_W = 16;
	localparam int STATUS_W = 2;

	// Voxel store geometry.
	localparam int STORE_DEPTH = 32768;
	localparam int CORNER_W = 3;
	localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

	// Reset value of the spread limit register (1.0 in Q3.12).
	localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RST = 16'd4096;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOB = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SPREAD = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic wr;
		logic base;
		logic rd;
		logic [CORNER_W-1:0] idx;
		logic fin;
	} vti_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic oob;
		logic sum_done;
	} vti_stat_t;

endpackage

`default_nettype wire

>>> rtl/vti_ram.sv
`default_nettype none

module vti_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port: write, or registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

>>> rtl/vti_datapath.sv
`default_nettype none

module vti_datapath #(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 32,
	parameter int FRAC_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire vti_pkg::vti_cmd_t cmd,
	output vti_pkg::vti_stat_t stat,
	input wire logic [vti_pkg::ADDR_W-1:0] voxel_address,
	input wire logic signed [vti_pkg::VAL_W-1:0] voxel_value,
	input wire logic [vti_pkg::COORD_W-1:0] coord_x,
	input wire logic [vti_pkg::COORD_W-1:0] coord_y,
	input wire logic [vti_pkg::COORD_W-1:0] coord_z,
	input wire logic cfg_wr_en,
	input wire logic [vti_pkg::LIMIT_W-1:0] cfg_wr_data,
	output logic signed [vti_pkg::VAL_W-1:0] interp_value,
	output logic [vti_pkg::STATUS_W-1:0] status
);

	import vti_pkg::*;

	// Widths of the blend chain: z pairs, then y pairs, then the x pair.
	localparam int CI_W = COORD_W - FRAC_BITS;
	localparam int W_W = FRAC_BITS + 1;
	localparam int M2_W = VAL_W + FRAC_BITS + 2;
	localparam int M4_W = M2_W + FRAC_BITS + 2;
	localparam int HL = FRAC_BITS + 10;
	localparam int HH_W = M4_W - HL;
	localparam int PH_W = HH_W + FRAC_BITS + 2;
	localparam int PL_W = HL + FRAC_BITS + 3;
	localparam int SH = 3 * FRAC_BITS;
	localparam int S_W = 3 * FRAC_BITS + 23;

	localparam logic [W_W-1:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [S_W-1:0] BIAS = S_W'(1) << (SH - 1);
	localparam logic [ADDR_W-1:0] OFF_X = ADDR_W'(GRID_Z);
	localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(GRID_X * GRID_Z);

	// Weight of the lower (hi = 0) or upper (hi = 1) neighbor on one axis.
	function automatic logic [W_W-1:0] wsel(input logic [FRAC_BITS-1:0] fr, input logic hi);
		return hi ? {1'b0, fr} : W_ONE - {1'b0, fr};
	endfunction

	logic [LIMIT_W-1:0] limit_q;
	logic [FRAC_BITS-1:0] frx_q, fry_q, frz_q;
	logic [CI_W-1:0] iz_q;
	logic [ADDR_W-1:0] row_q, base_q;
	logic oob_q;
	logic [ADDR_W-1:0] rd_addr, ram_addr;
	logic [VAL_W-1:0] ram_rdata;
	logic signed [VAL_W-1:0] rd_s;
	logic signed [VAL_W-1:0] mx_q, mn_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, sum_v_q;
	logic [CORNER_W-1:0] idx_s1, idx_s2;
	logic [1:0] gi_s3, gi_s4;
	logic hi_s5, hi_s6, hi_s7;
	logic signed [M2_W-1:0] m2, p_s2, g_hold_q, g_sum, g_s3;
	logic signed [M4_W-1:0] m4, q_s4, h_hold_q, h_sum, h_s5;
	logic signed [PH_W-1:0] m6h, ph_s6;
	logic signed [PL_W-1:0] m6l, pl_s6;
	logic [S_W-1:0] t_word, t_s7, sum_q, rnd;
	logic [W_W-1:0] w_x, w_y, w_z;
	logic [VAL_W:0] spread;

	// Spread limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SPREAD_LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Query capture: fractions, grid row and bounds check, then the base address.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frx_q <= coord_x[FRAC_BITS-1:0];
			fry_q <= coord_y[FRAC_BITS-1:0];
			frz_q <= coord_z[FRAC_BITS-1:0];
			iz_q <= coord_z[COORD_W-1:FRAC_BITS];
			row_q <= ADDR_W'(int'(coord_y[COORD_W-1:FRAC_BITS]) * GRID_X
				+ int'(coord_x[COORD_W-1:FRAC_BITS]));
			oob_q <= (int'(coord_x[COORD_W-1:FRAC_BITS]) >= GRID_X - 1)
				|| (int'(coord_y[COORD_W-1:FRAC_BITS]) >= GRID_Y - 1)
				|| (int'(coord_z[COORD_W-1:FRAC_BITS]) >= GRID_Z - 1);
		end
		if (cmd.base) begin
			base_q <= ADDR_W'(int'(row_q) * GRID_Z + int'(iz_q));
		end
	end

	// Corner address: bit 2 of the corner index steps x, bit 1 y, bit 0 z.
	always_comb begin
		rd_addr = base_q + (cmd.idx[2] ? OFF_X : '0) + (cmd.idx[1] ? OFF_Y : '0)
			+ ADDR_W'(cmd.idx[0]);
		ram_addr = cmd.wr ? voxel_address : rd_addr;
	end

	vti_ram #(
		.WIDTH(VAL_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(cmd.wr),
		.addr(ram_addr),
		.wdata(voxel_value),
		.rdata(ram_rdata)
	);

	// Blend arithmetic between the pipeline registers.
	always_comb begin
		rd_s = ram_rdata;
		w_z = wsel(frz_q, idx_s1[0]);
		w_y = wsel(fry_q, gi_s3[0]);
		w_x = wsel(frx_q, hi_s5);
		m2 = rd_s * $signed({1'b0, w_z});
		g_sum = g_hold_q + p_s2;
		m4 = g_s3 * $signed({1'b0, w_y});
		h_sum = h_hold_q + q_s4;
		m6h = $signed(h_s5[M4_W-1:HL]) * $signed({1'b0, w_x});
		m6l = $signed({1'b0, h_s5[HL-1:0]}) * $signed({1'b0, w_x});
		t_word = ({{(S_W-PH_W){ph_s6[PH_W-1]}}, ph_s6} << HL)
			+ {{(S_W-PL_W){pl_s6[PL_W-1]}}, pl_s6};
	end

	// Valid tags along the blend pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			sum_v_q <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2 & idx_s2[0];
			v_s4 <= v_s3;
			v_s5 <= v_s4 & gi_s4[0];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			sum_v_q <= v_s7 & hi_s7;
		end
	end

	// Blend pipeline payload; even members of each pair wait in a hold register.
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.idx;
		p_s2 <= m2;
		idx_s2 <= idx_s1;
		if (v_s2 && !idx_s2[0]) begin
			g_hold_q <= p_s2;
		end
		g_s3 <= g_sum;
		gi_s3 <= idx_s2[2:1];
		q_s4 <= m4;
		gi_s4 <= gi_s3;
		if (v_s4 && !gi_s4[0]) begin
			h_hold_q <= q_s4;
		end
		h_s5 <= h_sum;
		hi_s5 <= gi_s4[1];
		ph_s6 <= m6h;
		pl_s6 <= m6l;
		hi_s6 <= hi_s5;
		t_s7 <= t_word;
		hi_s7 <= hi_s6;
		if (v_s7) begin
			sum_q <= hi_s7 ? sum_q + t_s7 : t_s7;
		end
	end

	// Running maximum and minimum of the corners as they arrive.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (idx_s1 == '0) begin
				mx_q <= rd_s;
				mn_q <= rd_s;
			end else begin
				if (rd_s > mx_q) begin
					mx_q <= rd_s;
				end
				if (rd_s < mn_q) begin
					mn_q <= rd_s;
				end
			end
		end
	end

	// Result word: bounds first, then spread, then the rounded blend.
	always_comb begin
		spread = {mx_q[VAL_W-1], mx_q} - {mn_q[VAL_W-1], mn_q};
		rnd = sum_q + BIAS;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (oob_q) begin
				status <= ST_OOB;
				interp_value <= '0;
			end else if (spread > {1'b0, limit_q}) begin
				status <= ST_SPREAD;
				interp_value <= '0;
			end else begin
				status <= ST_VALID;
				interp_value <= rnd[SH+VAL_W-1:SH];
			end
		end
	end

	assign stat.oob = oob_q;
	assign stat.sum_done = sum_v_q;

endmodule

`default_nettype wire

>>> rtl/vti_ctrl.sv
`default_nettype none

module vti_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic command,
	output logic busy,
	output logic done,
	output vti_pkg::vti_cmd_t cmd,
	input wire vti_pkg::vti_stat_t stat
);

	import vti_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BASE,
		S_FETCH,
		S_WAIT
	} state_t;

	state_t state_q;
	logic [CORNER_W-1:0] cnt_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd = '0;
		cmd.idx = cnt_q;
		case (state_q)
			S_IDLE: begin
				cmd.wr = start & ~command;
				cmd.load = start & command;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				cmd.fin = stat.oob;
			end
			S_FETCH: begin
				cmd.rd = 1'b1;
			end
			S_WAIT: begin
				cmd.fin = stat.sum_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// State, corner counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && command) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					cnt_q <= '0;
					if (stat.oob) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CORNER) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (stat.sum_done) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/voxel_trilinear_interp.sv
// Write words produce no result; busy stays low, so they run back to back.
// A query in bounds forms its base address, then makes eight corner reads through the single port
// of the voxel memory, then the blend pipeline drains before its word returns; busy stays high until
// then. A query out of bounds returns its word from the base state and reads no corner.
// The result is on the ports with done, which is high for one cycle; the receiver cannot stall it.
// Reset (arst_n low) idles the controller and sets spread_limit to 4096; memory is not cleared.
`default_nettype none

module voxel_trilinear_interp #(
	parameter int GRID_X = 32,
	parameter int GRID_Y = 32,
	parameter int GRID_Z = 32,
	parameter int FRAC_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic command,
	input wire logic [vti_pkg::ADDR_W-1:0] voxel_address,
	input wire logic signed [vti_pkg::VAL_W-1:0] voxel_value,
	input wire logic [vti_pkg::COORD_W-1:0] coord_x,
	input wire logic [vti_pkg::COORD_W-1:0] coord_y,
	input wire logic [vti_pkg::COORD_W-1:0] coord_z,
	input wire logic cfg_wr_en,
	input wire logic [vti_pkg::LIMIT_W-1:0] cfg_wr_data,
	output logic done,
	output logic signed [vti_pkg::VAL_W-1:0] interp_value,
	output logic [vti_pkg::STATUS_W-1:0] status
);

	import vti_pkg::*;

	vti_cmd_t cmd;
	vti_stat_t stat;

	// Sequencer for writes, corner fetches and result hand-off.
	vti_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.command(command),
		.busy(busy),
		.done(done),
		.cmd(cmd),
		.stat(stat)
	);

	// Voxel memory, address generation and blend pipeline.
	vti_datapath #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z),
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.voxel_address(voxel_address),
		.voxel_value(voxel_value),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.interp_value(interp_value),
		.status(status)
	);

endmodule

`default_nettype wire

>>> dv/tb_voxel_trilinear_interp.sv
module tb_voxel_trilinear_interp;
	import vti_pkg::*;

	// Grid geometry; it matches the parameters given to the block below.
	localparam int GX = 32;
	localparam int GY = 32;
	localparam int GZ = 32;
	localparam int FRAC = 8;
	localparam int ONE = 1 << FRAC;
	localparam int FMASK = ONE - 1;
	localparam int COORD_MAX = (1 << COORD_W) - 1;

	// Command codes of an input word.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Quiet cycles allowed before a register write and at the end of the run.
	localparam int DRAIN_CYCLES = 24;
	// Cycles with no word moving in either direction before the run is abandoned.
	localparam int STALL_LIMIT = 1000;

	// Predicts each query's result from its own copy of the voxel grid and
	// checks the block's results against them in order.
	class trilinear_checker;
		logic signed [VAL_W-1:0] voxel_mem [STORE_DEPTH];
		logic [LIMIT_W-1:0] spread_limit;
		logic signed [VAL_W-1:0] exp_interp_q [$];
		logic [STATUS_W-1:0] exp_status_q [$];
		int errors;

		function new();
			spread_limit = SPREAD_LIMIT_RST;
			errors = 0;
		endfunction

		function void set_limit(input logic [LIMIT_W-1:0] lim);
			spread_limit = lim;
		endfunction

		function int pending();
			return exp_status_q.size();
		endfunction

		// Append one expected result word at the tail of the queues.
		function void queue_result(input logic signed [VAL_W-1:0] value,
				input logic [STATUS_W-1:0] stat);
			exp_interp_q.insert(exp_interp_q.size(), value);
			exp_status_q.insert(exp_status_q.size(), stat);
		endfunction

		// Note an accepted word: a write updates the grid, a query queues its result.
		function void note_word(input logic cmd, input logic [ADDR_W-1:0] addr,
				input logic signed [VAL_W-1:0] val, input logic [COORD_W-1:0] cx,
				input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
			int ix, iy, iz, hi, lo;
			int wx [2];
			int wy [2];
			int wz [2];
			int corner [8];
			longint acc;
			longint rounded;
			logic [ADDR_W-1:0] a;
			if (cmd == CMD_WRITE) begin
				voxel_mem[addr] = val;
				return;
			end
			ix = int'(cx) >> FRAC;
			iy = int'(cy) >> FRAC;
			iz = int'(cz) >> FRAC;
			// The bounds check comes before any corner is read.
			if (ix + 1 >= GX || iy + 1 >= GY || iz + 1 >= GZ) begin
				queue_result('0, ST_OOB);
				return;
			end
			// Corner index bits: bit 2 steps x, bit 1 steps y, bit 0 steps z.
			for (int i = 0; i < 8; i++) begin
				a = ADDR_W'(((iy + ((i >> 1) & 1)) * GX + ix + ((i >> 2) & 1)) * GZ
					+ iz + (i & 1));
				corner[i] = voxel_mem[a];
			end
			hi = corner[0];
			lo = corner[0];
			for (int i = 1; i < 8; i++) begin
				if (corner[i] > hi) hi = corner[i];
				if (corner[i] < lo) lo = corner[i];
			end
			if (hi - lo > int'(spread_limit)) begin
				queue_result('0, ST_SPREAD);
				return;
			end
			wx[1] = int'(cx) & FMASK;
			wx[0] = ONE - wx[1];
			wy[1] = int'(cy) & FMASK;
			wy[0] = ONE - wy[1];
			wz[1] = int'(cz) & FMASK;
			wz[0] = ONE - wz[1];
			acc = 0;
			for (int i = 0; i < 8; i++)
				acc += longint'(corner[i]) *
					longint'(wx[(i >> 2) & 1] * wy[(i >> 1) & 1] * wz[i & 1]);
			// Round to nearest with ties toward plus infinity.
			rounded = (acc + (longint'(1) << (3 * FRAC - 1))) >>> (3 * FRAC);
			queue_result(VAL_W'(rounded), ST_VALID);
		endfunction

		// Compare one result word against the oldest expected result.
		function void check_result(input logic signed [VAL_W-1:0] value,
				input logic [STATUS_W-1:0] stat);
			logic signed [VAL_W-1:0] exp_value;
			logic [STATUS_W-1:0] exp_stat;
			if (exp_status_q.size() == 0) begin
				$error("unexpected result word: interp_value=%0d status=%0d", value, stat);
				errors++;
				return;
			end
			exp_value = exp_interp_q.pop_front();
			exp_stat = exp_status_q.pop_front();
			if (stat !== exp_stat) begin
				$error("status: expected %0d, actual %0d", exp_stat, stat);
				errors++;
			end
			if (value !== exp_value) begin
				$error("interp_value: expected %0d, actual %0d", exp_value, value);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic command;
	logic [ADDR_W-1:0] voxel_address;
	logic signed [VAL_W-1:0] voxel_value;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [COORD_W-1:0] coord_z;
	logic cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;
	logic done;
	logic signed [VAL_W-1:0] interp_value;
	logic [STATUS_W-1:0] status;

	trilinear_checker sb;
	bit written [STORE_DEPTH];
	int burst_left;
	int idle_cycles;
	int words_sent;
	logic [LIMIT_W-1:0] cur_limit;

	voxel_trilinear_interp #(
		.GRID_X(GX),
		.GRID_Y(GY),
		.GRID_Z(GZ),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.voxel_address(voxel_address),
		.voxel_value(voxel_value),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.interp_value(interp_value),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Every result word is taken at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(interp_value, status);
	end

	// The watchdog restarts whenever a word moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("voxel_trilinear_interp regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y, input int z);
		return ADDR_W'((y * GX + x) * GZ + z);
	endfunction

	function automatic logic [COORD_W-1:0] rand_coord();
		return COORD_W'($urandom_range(0, COORD_MAX));
	endfunction

	// Present one word, hold it until accepted, then pace the sender in bursts.
	task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] addr,
			input logic signed [VAL_W-1:0] val, input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
		start <= 1'b1;
		command <= cmd;
		voxel_address <= addr;
		voxel_value <= val;
		coord_x <= cx;
		coord_y <= cy;
		coord_z <= cz;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(cmd, addr, val, cx, cy, cz);
		words_sent++;
		if (cmd == CMD_WRITE)
			written[addr] = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
		end
	endtask

	task automatic send_query(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
			input logic [COORD_W-1:0] cz);
		send_word(CMD_QUERY, ADDR_W'($urandom()), VAL_W'($urandom()), cx, cy, cz);
	endtask

	// Write the eight corners of a cell, or only the ones never written.
	// Values are base plus up to span, or exactly base or base plus span.
	task automatic fill_cell(input int ix, input int iy, input int iz, input bit overwrite,
			input int base, input int span, input bit two_level);
		logic [ADDR_W-1:0] a;
		int v;
		for (int i = 0; i < 8; i++) begin
			a = cell_addr(ix + ((i >> 2) & 1), iy + ((i >> 1) & 1), iz + (i & 1));
			if (overwrite || !written[a]) begin
				if (two_level)
					v = base + ($urandom_range(0, 1) ? span : 0);
				else
					v = base + int'($urandom_range(0, span));
				if (v > 32767) v = 32767;
				send_word(CMD_WRITE, a, VAL_W'(v), rand_coord(), rand_coord(), rand_coord());
			end
		end
	endtask

	// Change the spread limit once the block has gone quiet.
	task automatic write_spread_limit(input logic [LIMIT_W-1:0] lim);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_limit(lim);
		cur_limit = lim;
	endtask

	// Mostly whole cell-then-query sequences, plus stray queries and stray writes.
	task automatic random_words(input int count);
		int stop_at, pick, ix, iy, iz, base, span;
		bit two_level;
		logic [COORD_W-1:0] cx, cy, cz;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			base = int'($urandom_range(0, 65535)) - 32768;
			two_level = 1'b0;
			case ($urandom_range(0, 6))
				0: span = 0;
				1: span = 15;
				2: span = 255;
				3: span = 4095;
				4: span = 4096;
				5: span = 65535;
				default: begin
					span = int'(cur_limit) + int'($urandom_range(0, 1));
					two_level = 1'b1;
				end
			endcase
			if (pick < 70) begin
				ix = $urandom_range(0, GX - 2);
				iy = $urandom_range(0, GY - 2);
				iz = $urandom_range(0, GZ - 2);
				cx = COORD_W'((ix << FRAC) | $urandom_range(0, FMASK));
				cy = COORD_W'((iy << FRAC) | $urandom_range(0, FMASK));
				cz = COORD_W'((iz << FRAC) | $urandom_range(0, FMASK));
				fill_cell(ix, iy, iz, $urandom_range(0, 3) != 0, base, span, two_level);
				send_query(cx, cy, cz);
			end else if (pick < 85) begin
				cx = rand_coord();
				cy = rand_coord();
				cz = rand_coord();
				ix = int'(cx) >> FRAC;
				iy = int'(cy) >> FRAC;
				iz = int'(cz) >> FRAC;
				// A query inside the grid may only read corners already written.
				if (ix + 1 < GX && iy + 1 < GY && iz + 1 < GZ)
					fill_cell(ix, iy, iz, 1'b0, base, span, two_level);
				send_query(cx, cy, cz);
			end else begin
				send_word(CMD_WRITE, ADDR_W'($urandom()), VAL_W'($urandom()),
					rand_coord(), rand_coord(), rand_coord());
			end
		end
	endtask

	initial begin
		sb = new();
		cur_limit = SPREAD_LIMIT_RST;
		burst_left = 0;
		words_sent = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_WRITE;
		voxel_address <= '0;
		voxel_value <= '0;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Most negative cell at the origin, most positive cell at the far corner.
		fill_cell(0, 0, 0, 1'b1, -32768, 0, 1'b0);
		send_query('0, '0, '0);
		fill_cell(GX - 2, GY - 2, GZ - 2, 1'b1, 32767, 0, 1'b0);
		send_query(COORD_W'(((GX - 1) << FRAC) - 1), COORD_W'(((GY - 1) << FRAC) - 1),
			COORD_W'(((GZ - 1) << FRAC) - 1));

		// Upper neighbor outside the grid on all axes, then on each axis alone.
		send_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
		send_query(COORD_W'((GX - 1) << FRAC), '0, '0);
		send_query('0, COORD_W'((GY - 1) << FRAC), '0);
		send_query('0, '0, COORD_W'((GZ - 1) << FRAC));

		// A blend that lands exactly halfway must round toward plus infinity.
		send_word(CMD_WRITE, cell_addr(0, 0, 0), -16'sd32764, '0, '0, '0);
		send_query(COORD_W'(ONE / 2), COORD_W'(ONE / 2), COORD_W'(ONE / 2));

		// One corner far above the rest makes the spread too large.
		send_word(CMD_WRITE, cell_addr(0, 0, 1), 16'sd32767, '0, '0, '0);
		send_query('0, '0, '0);

		random_words(100);
		write_spread_limit('0);
		random_words(80);
		write_spread_limit('1);
		random_words(80);
		write_spread_limit(SPREAD_LIMIT_RST);
		random_words(80);
		write_spread_limit(LIMIT_W'($urandom_range(0, 8191)));
		random_words(80);
		write_spread_limit(LIMIT_W'(1));
		random_words(80);
		write_spread_limit(LIMIT_W'($urandom()));
		random_words(80);

		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("voxel_trilinear_interp regression: pass");
		else
			$display("voxel_trilinear_interp regression: fail");
		$finish;
	end

endmodule
